// ===== src/crfsm_pkg.sv =====
// shared types, constants and verdict helper for the chain reset confirmation block
package crfsm_pkg;

   localparam int unsigned ID_WORDS  = 4;
   localparam int unsigned WORD_W    = 64;
   localparam int unsigned INDEX_W   = 5;
   localparam int unsigned POLL_W    = 8;
   localparam int unsigned REQ_DATA_W = 264;
   localparam int unsigned RSP_DATA_W = 8;

   localparam logic [INDEX_W-1:0] WITNESS_EMPTY = 5'h1f;
   localparam logic [POLL_W-1:0]  POLL_MAX      = 8'hff;

   typedef enum logic [1:0] {
      VERDICT_NO        = 2'd0,
      VERDICT_PENDING   = 2'd1,
      VERDICT_CONFIRMED = 2'd2
   } verdict_type;

   typedef logic [ID_WORDS-1:0][WORD_W-1:0] chain_id_type;

   typedef struct packed {
      chain_id_type              obs_id;
      logic signed [INDEX_W-1:0] server_idx;
   } item_type;

   // confirmed needs two polls from two distinct servers
   function automatic verdict_type tracked_verdict(
      input logic [POLL_W-1:0]  poll,
      input logic [INDEX_W-1:0] first,
      input logic [INDEX_W-1:0] second
   );
      verdict_type v;
      v = VERDICT_PENDING;
      if ((poll >= 8'd2) && (first != WITNESS_EMPTY) && (second != WITNESS_EMPTY)) begin
         v = VERDICT_CONFIRMED;
      end
      return v;
   endfunction

endpackage

// ===== src/crfsm_in_stage.sv =====
// input register holding one request until the core consumes it
module crfsm_in_stage
   import crfsm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== src/crfsm_core.sv =====
// reference and candidate tracking state with the per-request decision logic
module crfsm_core
   import crfsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  item_type    item,
   output verdict_type verdict
);

   chain_id_type       reference_ff, reference_in;
   chain_id_type       candidate_ff, candidate_in;
   logic               cand_valid_ff, cand_valid_in;
   logic [INDEX_W-1:0] first_ff, first_in;
   logic [INDEX_W-1:0] second_ff, second_in;
   logic [POLL_W-1:0]  poll_ff, poll_in;

   logic               query;
   logic               ref_unset;
   logic               match_ref;
   logic               match_cand;
   logic [INDEX_W-1:0] idx;

   assign idx        = item.server_idx;
   assign query      = idx[INDEX_W-1];
   assign ref_unset  = (reference_ff == '0);
   assign match_ref  = (item.obs_id == reference_ff);
   assign match_cand = cand_valid_ff && (item.obs_id == candidate_ff);

   always_comb begin
      reference_in  = reference_ff;
      candidate_in  = candidate_ff;
      cand_valid_in = cand_valid_ff;
      first_in      = first_ff;
      second_in     = second_ff;
      poll_in       = poll_ff;
      verdict       = VERDICT_NO;
      if (query) begin
         if (cand_valid_ff) begin
            verdict = tracked_verdict(poll_ff, first_ff, second_ff);
         end
      end else if (ref_unset || match_ref) begin
         if (ref_unset) begin
            reference_in = item.obs_id;
         end
         cand_valid_in = 1'b0;
         first_in      = WITNESS_EMPTY;
         second_in     = WITNESS_EMPTY;
         poll_in       = '0;
      end else if (!match_cand) begin
         candidate_in  = item.obs_id;
         cand_valid_in = 1'b1;
         first_in      = idx;
         second_in     = WITNESS_EMPTY;
         poll_in       = 8'd1;
         verdict       = VERDICT_PENDING;
      end else begin
         if (poll_ff != POLL_MAX) begin
            poll_in = poll_ff + 8'd1;
         end
         // only the first two distinct servers are recorded
         if ((first_ff != idx) && (second_ff != idx)) begin
            if (first_ff == WITNESS_EMPTY) begin
               first_in = idx;
            end else if (second_ff == WITNESS_EMPTY) begin
               second_in = idx;
            end
         end
         verdict = tracked_verdict(poll_in, first_in, second_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reference_ff  <= '0;
         cand_valid_ff <= 1'b0;
         first_ff      <= WITNESS_EMPTY;
         second_ff     <= WITNESS_EMPTY;
         poll_ff       <= '0;
      end else if (step) begin
         reference_ff  <= reference_in;
         cand_valid_ff <= cand_valid_in;
         first_ff      <= first_in;
         second_ff     <= second_in;
         poll_ff       <= poll_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         candidate_ff <= candidate_in;
      end
   end

`ifndef SYNTH
   a_match_clears: assert property (@(posedge clock) disable iff (reset)
      (step && !query && !ref_unset && match_ref) |=> !cand_valid_ff)
      else $error("tracking not cleared after reference match");

   a_idle_tracking: assert property (@(posedge clock) disable iff (reset)
      !cand_valid_ff |-> (poll_ff == '0 && first_ff == WITNESS_EMPTY
                          && second_ff == WITNESS_EMPTY))
      else $error("tracking state left over without a candidate");

   a_witness_distinct: assert property (@(posedge clock) disable iff (reset)
      (second_ff != WITNESS_EMPTY) |-> (first_ff != second_ff && first_ff != WITNESS_EMPTY))
      else $error("witness slots inconsistent");

   a_query_holds: assert property (@(posedge clock) disable iff (reset)
      (step && query) |=> ($stable(poll_ff) && $stable(cand_valid_ff) && $stable(reference_ff)))
      else $error("status query changed state");
`endif

endmodule

// ===== src/crfsm_out_stage.sv =====
// result register holding the verdict until the consumer takes it
module crfsm_out_stage
   import crfsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  verdict_type verdict,
   output logic        free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output verdict_type rsp_verdict
);

   logic        valid_ff, valid_in;
   verdict_type verdict_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         verdict_ff <= verdict;
      end
   end

   assign rsp_tvalid  = valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule

// ===== src/chain_reset_confirm_fsm.sv =====
// top level of the chain reset confirmation block
// Each request carries one observation (a 256-bit chain identifier and the
// reporting server index) and yields exactly one verdict: 0 no reset,
// 1 pending, 2 confirmed. A new request can be taken every cycle while the
// consumer keeps rsp_tready high; a verdict passes through the input
// register and then the result register, with the identifier compares and
// tracking update done combinationally between them. Requests are processed
// strictly in order, so each sees the state left by the previous.
// A negative server index only reports the current status.
module chain_reset_confirm_fsm
   import crfsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // id_w0 [63:0], id_w1 [127:64], id_w2 [191:128],
   // id_w3 [255:192], server_idx [260:256], zero pad [263:261]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // verdict [1:0], zero pad [7:2]
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   item_type    req_item;
   item_type    item;
   logic        item_valid;
   logic        advance;
   logic        out_free;
   verdict_type verdict;
   verdict_type rsp_verdict;

   assign req_item = '{obs_id: req_tdata[255:0], server_idx: req_tdata[260:256]};

   assign advance = item_valid && out_free;

   crfsm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   crfsm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .item    (item),
      .verdict (verdict)
   );

   crfsm_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (advance),
      .verdict     (verdict),
      .free        (out_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_verdict (rsp_verdict)
   );

   assign rsp_tdata = {6'b0, rsp_verdict};

endmodule

// ===== tb/chain_reset_confirm_fsm_checker.sv =====
// checker for the chain reset confirmation block: predicts each verdict and compares
`timescale 1ns / 100ps

module chain_reset_confirm_fsm_checker
   import crfsm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   // id_w0 [63:0], id_w1 [127:64], id_w2 [191:128],
   // id_w3 [255:192], server_idx [260:256], zero pad [263:261]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // verdict [1:0], zero pad [7:2]
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                    fail_count,
   output int                    verdicts_owed
);

   chain_id_type       reference_chain;
   chain_id_type       candidate_chain;
   logic               candidate_live;
   logic [INDEX_W-1:0] witness_a;
   logic [INDEX_W-1:0] witness_b;
   logic [POLL_W-1:0]  poll_tally;
   verdict_type        verdicts_due[$];

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $time, what);
      fail_count = fail_count + 1;
   endtask

   task automatic drop_tracking();
      candidate_live = 1'b0;
      witness_a      = WITNESS_EMPTY;
      witness_b      = WITNESS_EMPTY;
      poll_tally     = '0;
   endtask

   function automatic verdict_type tracking_verdict();
      int unsigned servers;
      servers = (witness_a != WITNESS_EMPTY) + (witness_b != WITNESS_EMPTY);
      if (poll_tally >= 2 && servers >= 2) return VERDICT_CONFIRMED;
      return VERDICT_PENDING;
   endfunction

   // applies one observation to the tracked state and gives its verdict
   task automatic judge_observation(
      input  chain_id_type       obs,
      input  logic [INDEX_W-1:0] server,
      output verdict_type        verdict
   );
      if (server[INDEX_W-1]) begin
         // status query, state untouched
         verdict = candidate_live ? tracking_verdict() : VERDICT_NO;
      end else if (reference_chain == '0) begin
         reference_chain = obs;
         drop_tracking();
         verdict = VERDICT_NO;
      end else if (obs == reference_chain) begin
         drop_tracking();
         verdict = VERDICT_NO;
      end else if (!candidate_live || obs != candidate_chain) begin
         candidate_chain = obs;
         candidate_live  = 1'b1;
         witness_a       = server;
         witness_b       = WITNESS_EMPTY;
         poll_tally      = 8'd1;
         verdict = VERDICT_PENDING;
      end else begin
         if (poll_tally != POLL_MAX) poll_tally = poll_tally + 8'd1;
         if (witness_a != server && witness_b != server) begin
            if (witness_a == WITNESS_EMPTY) witness_a = server;
            else if (witness_b == WITNESS_EMPTY) witness_b = server;
         end
         verdict = tracking_verdict();
      end
   endtask

   always @(posedge clock) begin
      verdict_type next_verdict;
      verdict_type seen;
      if (reset) begin
         reference_chain = '0;
         candidate_chain = '0;
         drop_tracking();
         verdicts_due.delete();
         fail_count = 0;
         verdicts_owed <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("verdict %0d with no request outstanding",
                                         rsp_tdata[1:0]));
            end else begin
               seen = verdict_type'(rsp_tdata[1:0]);
               next_verdict = verdicts_due.pop_front();
               if (rsp_tdata[1:0] !== next_verdict)
                  report_mismatch($sformatf("verdict %0d, expected %0d",
                                            rsp_tdata[1:0], next_verdict));
               if (rsp_tdata[RSP_DATA_W-1:2] !== '0)
                  report_mismatch($sformatf("pad bits 0x%0h on verdict %s",
                                            rsp_tdata[RSP_DATA_W-1:2], seen.name()));
            end
         end
         if (req_tvalid && req_tready) begin
            judge_observation(req_tdata[ID_WORDS*WORD_W-1:0],
                              req_tdata[ID_WORDS*WORD_W +: INDEX_W], next_verdict);
            verdicts_due.push_back(next_verdict);
         end
         verdicts_owed <= verdicts_due.size();
      end
   end

endmodule

// ===== tb/chain_reset_confirm_fsm_tb.sv =====
// testbench top for the chain reset confirmation block: stimulus, backpressure and verdict
`timescale 1ns / 100ps

module chain_reset_confirm_fsm_tb;
   import crfsm_pkg::*;

   localparam int STALL_LIMIT  = 1000;
   localparam int HOLD_CYCLES  = 60;
   localparam int RANDOM_ITEMS = 160;
   localparam int CALM_ITEMS   = 40;
   localparam int SATURATE_RUN = 270;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    fail_count;
   int                    verdicts_owed;

   bit           idling_on    = 1'b1;
   bit           hold_off_req = 1'b0;
   int           random_sent  = 0;
   int           quiet_cycles = 0;
   chain_id_type home_chain;
   chain_id_type near_miss[ID_WORDS];

   chain_reset_confirm_fsm dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   chain_reset_confirm_fsm_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .verdicts_owed (verdicts_owed)
   );

   always #1 clock = ~clock;

   function automatic chain_id_type random_chain();
      return {$urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   // offers one observation and returns once the request is taken
   task automatic send_observation(input chain_id_type obs, input logic [INDEX_W-1:0] server);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, server, obs};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_status();
      logic [INDEX_W-1:0] query;
      query = INDEX_W'($urandom_range(16, 31));
      send_observation(random_chain(), query);
   endtask

   // one burst of polls around a single candidate, with noise mixed in
   task automatic run_episode();
      chain_id_type       pick;
      logic [INDEX_W-1:0] server;
      int                 roll;
      int                 reps;
      case ($urandom_range(0, 7))
         0:       pick = random_chain();
         1:       pick = '0;
         2:       pick = '1;
         default: pick = near_miss[$urandom_range(0, ID_WORDS-1)];
      endcase
      reps = $urandom_range(1, 8);
      repeat (reps) begin
         roll = $urandom_range(0, 19);
         server = (roll < 16) ? INDEX_W'($urandom_range(0, 3))
                              : INDEX_W'($urandom_range(0, 15));
         if (roll < 3) send_status();
         else if (roll == 3) send_observation(home_chain, server);
         else if (roll == 4) send_observation(random_chain(), server);
         else send_observation(pick, server);
         random_sent++;
         if (random_sent >= RANDOM_ITEMS - CALM_ITEMS) idling_on = 1'b0;
      end
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 11) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      chain_id_type ones_chain;
      home_chain    = random_chain();
      home_chain[0][0] = 1'b1;
      ones_chain    = '1;
      for (int w = 0; w < ID_WORDS; w++) begin
         near_miss[w] = home_chain;
         near_miss[w][w][$urandom_range(0, WORD_W-1)] ^= 1'b1;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: unset reference, tracking, witnesses, matches
      send_observation('0, 5'h1f);
      send_observation('0, 5'd0);
      send_observation(random_chain(), 5'h10);
      send_observation(home_chain, 5'd15);
      send_observation('0, 5'd0);
      send_observation('0, 5'd0);
      send_observation(random_chain(), 5'h1f);
      send_observation('0, 5'd15);
      send_observation('0, 5'd9);
      send_observation('1, 5'h18);
      send_observation(home_chain, 5'd4);
      send_observation(ones_chain, 5'h1f);
      send_observation(ones_chain, 5'd1);
      send_observation('0, 5'd1);
      send_observation('0, 5'd2);
      send_observation(ones_chain, 5'd3);
      send_observation(near_miss[3], 5'd3);
      send_observation(near_miss[3], 5'd5);
      send_observation(home_chain, 5'd0);

      // random part, opening with a long receiver hold-off
      hold_off_req = 1'b1;
      while (random_sent < RANDOM_ITEMS / 2) run_episode();

      // long run on one candidate so the poll count saturates
      send_observation(near_miss[0], 5'd6);
      repeat (SATURATE_RUN) send_observation(near_miss[0], INDEX_W'($urandom_range(0, 15)));
      send_status();

      while (random_sent < RANDOM_ITEMS) run_episode();

      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (verdicts_owed == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
